// File: hw/rtl/ffpra_pkg.sv
`default_nettype none

package ffpra_pkg;

    // map geometry
    localparam int MAP_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int CNT_W     = $clog2(MAP_DEPTH + 1);

    // field widths
    localparam int LEN_W     = 11;
    localparam int FRAME_W   = 20;
    localparam int ENTRY_W   = 11;
    localparam int EXP_W     = ENTRY_W + 1;
    localparam int WIDE_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int SUM_W     = WIDE_W + 2;

    // stream packing
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;

    // configuration register indexes
    localparam logic CFG_BASE_FRAME   = 1'b0;
    localparam logic CFG_PAGES_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_NO_ROOM  = 2'd1,
        STATUS_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ADDR_POS = 2'd0,
        ADDR_RUN = 2'd1,
        ADDR_CLR = 2'd2
    } addr_sel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_START,
        ST_A_RD,
        ST_A_CHK,
        ST_A_WR,
        ST_F_START,
        ST_F_RD,
        ST_F_CHK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic      item_load;
        logic      clr_step;
        logic      pos_zero;
        logic      pos_jump;
        logic      idx_inc;
        logic      idx_zero;
        logic      free_init;
        logic      free_step;
        logic      ram_wr;
        addr_sel_t addr_sel;
        logic      wdata_seq;
        logic      res_set;
        status_t   res_code;
        logic      res_first_en;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic len_bad;
        logic jump_fits;
        logic idx_last;
        logic entry_zero;
        logic entry_match;
        logic exp_first;
        logic off_ok;
        logic next_in;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/first_fit_page_run_allocator.sv
// result path: an allocate checks the length, then reads and checks map entries in turn
//   and writes the run numbers on success; a free checks the offset, then reads, checks
//   and clears entries in turn; each result waits in ST_FIN for the output register
// throughput: one item at a time; the next transfer is taken once the result is registered
// reset: aresetn synchronous active low; then a clearing pass zeroes all 1024 frame map
//   entries (one entry per cycle) with s_tready low, config writes are taken throughout
`default_nettype none

module first_fit_page_run_allocator
    import ffpra_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // configuration write port: index 0 base_frame, index 1 pages_in_use
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_index,
    input  wire logic [FRAME_W-1:0]   cfg_wdata,

    // request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // run_length[10:0], free_frame[30:11], pad
    input  wire logic                 s_tuser,   // kind: 0 allocate, 1 free

    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_DATA_W-1:0]  m_tdata    // status[1:0], first_frame[21:2], pad
);

    ctrl_cmd_t          cmd;
    dp_status_t         st;
    logic [1:0]         m_status;
    logic [FRAME_W-1:0] m_first_frame;

    // sequencer: clearing pass, first-fit scan, run numbering, free walk
    ffpra_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .item_kind (s_tuser),
        .s_tready  (s_tready),
        .st        (st),
        .cmd       (cmd)
    );

    // frame map, scan pointers and the output register
    // the top pad bit of s_tdata carries nothing
    ffpra_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .item_len      (s_tdata[LEN_W-1:0]),
        .item_frame    (s_tdata[LEN_W+FRAME_W-1:LEN_W]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_status      (m_status),
        .m_first_frame (m_first_frame),
        .cmd           (cmd),
        .st            (st)
    );

    // pack the result transfer, zero padding on top
    assign m_tdata = {{(M_DATA_W - FRAME_W - 2){1'b0}}, m_first_frame, m_status};

endmodule

`default_nettype wire

// File: hw/rtl/ffpra_ram.sv
`default_nettype none

module ffpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/ffpra_datapath.sv
`default_nettype none

module ffpra_datapath
    import ffpra_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_index,
    input  wire logic [FRAME_W-1:0]  cfg_wdata,
    input  wire logic [LEN_W-1:0]    item_len,
    input  wire logic [FRAME_W-1:0]  item_frame,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic      [1:0]          m_status,
    output logic      [FRAME_W-1:0]  m_first_frame,
    input  wire ctrl_cmd_t           cmd,
    output dp_status_t               st
);

    logic [FRAME_W-1:0] base_reg;
    logic [LEN_W-1:0]   pages_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [LEN_W-1:0]   idx_reg;
    logic [EXP_W-1:0]   exp_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    status_t            res_status_reg;
    logic [FRAME_W-1:0] res_first_reg;
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [FRAME_W-1:0] out_first_reg;

    logic [WIDE_W-1:0]  cnt;
    logic [SUM_W-1:0]   run_pos;
    logic [SUM_W-1:0]   jump_pos;
    logic [FRAME_W-1:0] off;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    // managed frame count, capped at the map depth
    assign cnt = (WIDE_W'(pages_reg) > WIDE_W'(MAP_DEPTH)) ? WIDE_W'(MAP_DEPTH)
                                                          : WIDE_W'(pages_reg);
    assign run_pos  = SUM_W'(pos_reg) + SUM_W'(idx_reg);
    assign jump_pos = run_pos + SUM_W'(1);
    assign off      = frame_reg - base_reg;

    always_comb begin
        case (cmd.addr_sel)
            ADDR_RUN: ram_addr = run_pos[ADDR_W-1:0];
            ADDR_CLR: ram_addr = clr_addr_reg;
            default:  ram_addr = pos_reg[ADDR_W-1:0];
        endcase
    end

    assign ram_wdata = cmd.wdata_seq ? ENTRY_W'(idx_reg + LEN_W'(1)) : '0;

    ffpra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (aclk),
        .we    (cmd.ram_wr),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        st.clr_last    = (clr_addr_reg == ADDR_W'(MAP_DEPTH - 1));
        st.len_bad     = (len_reg == '0) || (WIDE_W'(len_reg) > cnt);
        st.jump_fits   = (jump_pos + SUM_W'(len_reg)) <= SUM_W'(cnt);
        st.idx_last    = (SUM_W'(idx_reg) + SUM_W'(1)) == SUM_W'(len_reg);
        st.entry_zero  = (ram_rdata == '0);
        st.entry_match = ({1'b0, ram_rdata} == exp_reg);
        st.exp_first   = (exp_reg == EXP_W'(1));
        st.off_ok      = off < FRAME_W'(cnt);
        st.next_in     = (SUM_W'(pos_reg) + SUM_W'(1)) < SUM_W'(cnt);
        st.out_busy    = out_valid_reg && !m_tready;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            pages_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BASE_FRAME:   base_reg  <= cfg_wdata;
                CFG_PAGES_IN_USE: pages_reg <= cfg_wdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // clearing pass address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            len_reg   <= item_len;
            frame_reg <= item_frame;
        end
        if (cmd.pos_zero) begin
            pos_reg <= '0;
        end else if (cmd.pos_jump) begin
            pos_reg <= jump_pos[CNT_W-1:0];
        end else if (cmd.free_init) begin
            pos_reg <= off[CNT_W-1:0];
        end else if (cmd.free_step) begin
            pos_reg <= pos_reg + CNT_W'(1);
        end
        if (cmd.pos_zero || cmd.pos_jump || cmd.idx_zero) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + LEN_W'(1);
        end
        if (cmd.free_init) begin
            exp_reg <= EXP_W'(1);
        end else if (cmd.free_step) begin
            exp_reg <= exp_reg + EXP_W'(1);
        end
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_code;
            res_first_reg  <= cmd.res_first_en ? (base_reg + FRAME_W'(pos_reg)) : '0;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_first_reg  <= res_first_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_first_frame = out_first_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ffpra_ctrl.sv
`default_nettype none

module ffpra_ctrl
    import ffpra_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        item_kind,
    output logic             s_tready,
    input  wire dp_status_t  st,
    output ctrl_cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (st.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = item_kind ? ST_F_START : ST_A_START;
            end
            ST_A_START: begin
                state_next = st.len_bad ? ST_FIN : ST_A_RD;
            end
            ST_A_RD: begin
                state_next = ST_A_CHK;
            end
            ST_A_CHK: begin
                if (!st.entry_zero) begin
                    state_next = st.jump_fits ? ST_A_RD : ST_FIN;
                end else begin
                    state_next = st.idx_last ? ST_A_WR : ST_A_RD;
                end
            end
            ST_A_WR: begin
                if (st.idx_last) state_next = ST_FIN;
            end
            ST_F_START: begin
                state_next = st.off_ok ? ST_F_RD : ST_FIN;
            end
            ST_F_RD: begin
                state_next = ST_F_CHK;
            end
            ST_F_CHK: begin
                state_next = (st.entry_match && st.next_in) ? ST_F_RD : ST_FIN;
            end
            ST_FIN: begin
                if (!st.out_busy) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.addr_sel = ADDR_POS;
        cmd.res_code = STATUS_DONE;
        s_tready     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                cmd.ram_wr   = 1'b1;
                cmd.addr_sel = ADDR_CLR;
            end
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.item_load = s_tvalid;
            end
            ST_A_START: begin
                if (st.len_bad) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STATUS_NO_ROOM;
                end else begin
                    cmd.pos_zero = 1'b1;
                end
            end
            ST_A_RD: begin
                cmd.addr_sel = ADDR_RUN;
            end
            ST_A_CHK: begin
                if (!st.entry_zero) begin
                    cmd.pos_jump = 1'b1;
                    if (!st.jump_fits) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = STATUS_NO_ROOM;
                    end
                end else if (st.idx_last) begin
                    cmd.idx_zero = 1'b1;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_A_WR: begin
                cmd.addr_sel  = ADDR_RUN;
                cmd.ram_wr    = 1'b1;
                cmd.wdata_seq = 1'b1;
                if (st.idx_last) begin
                    cmd.res_set      = 1'b1;
                    cmd.res_code     = STATUS_DONE;
                    cmd.res_first_en = 1'b1;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_F_START: begin
                if (st.off_ok) begin
                    cmd.free_init = 1'b1;
                end else begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STATUS_BAD_FREE;
                end
            end
            ST_F_RD: begin
                cmd.addr_sel = ADDR_POS;
            end
            ST_F_CHK: begin
                cmd.addr_sel = ADDR_POS;
                if (st.entry_match) begin
                    cmd.ram_wr    = 1'b1;
                    cmd.free_step = 1'b1;
                    if (!st.next_in) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = STATUS_DONE;
                    end
                end else begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = st.exp_first ? STATUS_BAD_FREE : STATUS_DONE;
                end
            end
            ST_FIN: begin
                cmd.out_load = !st.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/ffpra_checker.sv
`default_nettype none

module ffpra_checker
    import ffpra_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_DATA_W-1:0]  m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // status is one of done, no room, bad free
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // failed items carry frame zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != STATUS_DONE |-> m_tdata[21:2] == '0)
        else $error("failed item with nonzero frame");

    // one item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("channel active after reset");

endmodule

bind first_fit_page_run_allocator ffpra_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
